### design/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg - shared types and codes for the tagged stack machine step block
// Tagged word, result item layout, command and outcome codes.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int CMD_W   = 3;
  localparam int DEPTH_W = 4;
  localparam int PC_W    = 8;
  localparam int VALUE_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_NOOP    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STORE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADD     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_HALT    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RESTART = 3'd7;

  // outcome codes, also used as the sticky stop code (stepped means running)
  localparam logic [1:0] OC_STEPPED = 2'd0;
  localparam logic [1:0] OC_ERRORED = 2'd1;
  localparam logic [1:0] OC_HALTED  = 2'd2;
  localparam logic [1:0] OC_EXITED  = 2'd3;

  localparam logic [PC_W-1:0] PROG_LEN_RESET = 8'd4;

  typedef struct packed {
    logic               tag;
    logic [VALUE_W-1:0] value;
  } word_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [PC_W-1:0]    prog_counter;
    logic [DEPTH_W-1:0] stack_depth;
    word_t              top;
  } res_t;

endpackage

### design/tagged_stack_machine_step.sv
// ----------------------------------------------------------------------------
// tagged_stack_machine_step - one-instruction-per-item tagged stack machine
// Executes noop, push, pop, load, store, add, halt and restart on a small
// stack machine whose words carry a one-bit security tag.
// ----------------------------------------------------------------------------
// Each accepted command item is executed in the cycle it is accepted; the
// result goes to the output register, or to the skid entry while res_stall
// holds it; with no res_stall one item per clock is sustained. The rate is set
// by the single execute pass: stack top, second entry and the addressed data
// memory word are all read from flip-flops, the one 32-bit add and the
// address compare sit between those registers and the result register. The
// output side has two entries (output register and skid entry); cmd_stall
// rises only when both hold items, so a new command is taken while a result
// still waits. cfg_ready is always high; write program_length only while the
// block is idle. Restart clears the data memory at once through per-word
// valid bits, so there is no clearing sweep after reset or restart. Errors,
// halt and program end stick until a restart command.
// ----------------------------------------------------------------------------
module tagged_stack_machine_step #(
  parameter int STACK_DEPTH = 10,
  parameter int MEM_WORDS   = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  // command channel
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [tsm_pkg::CMD_W-1:0]          command,
  input  logic signed [tsm_pkg::VALUE_W-1:0] imm_value,
  input  logic                               imm_tag,
  // result channel
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [1:0]                         outcome,
  output logic [tsm_pkg::PC_W-1:0]           prog_counter,
  output logic [tsm_pkg::DEPTH_W-1:0]        stack_depth,
  output logic signed [tsm_pkg::VALUE_W-1:0] top_value,
  output logic                               top_tag,
  // program_length write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsm_pkg::PC_W-1:0]           cfg_data
);
  import tsm_pkg::*;

  logic fire;
  logic buf_full;
  res_t step_res;
  res_t out_res;

  // accept a command item only while the result buffer has room
  assign cmd_stall = buf_full;
  assign fire      = cmd_valid && !cmd_stall;

  // configuration is always taken; the register sits in the core
  assign cfg_ready = 1'b1;

  tsm_core #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_WORDS   (MEM_WORDS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .command   (command),
    .imm_value (imm_value),
    .imm_tag   (imm_tag),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .result    (step_res)
  );

  // hold finished result items until the consumer takes them
  tsm_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .data      (step_res),
    .res_stall (res_stall),
    .full      (buf_full),
    .res_valid (res_valid),
    .res       (out_res)
  );

  assign outcome      = out_res.outcome;
  assign prog_counter = out_res.prog_counter;
  assign stack_depth  = out_res.stack_depth;
  assign top_value    = out_res.top.value;
  assign top_tag      = out_res.top.tag;

endmodule

### design/tsm_core.sv
// ----------------------------------------------------------------------------
// tsm_core - machine state and combinational execute
// Holds the stack as a shift line, the tagged data memory and the control
// registers; works out the next state and the result item of each command.
// ----------------------------------------------------------------------------
module tsm_core #(
  parameter int STACK_DEPTH = 10,
  parameter int MEM_WORDS   = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fire,
  input  logic [tsm_pkg::CMD_W-1:0]       command,
  input  logic signed [tsm_pkg::VALUE_W-1:0] imm_value,
  input  logic                            imm_tag,
  input  logic                            cfg_we,
  input  logic [tsm_pkg::PC_W-1:0]        cfg_data,
  output tsm_pkg::res_t                   result
);
  import tsm_pkg::*;

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(STACK_DEPTH);
  localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] DEPTH_TWO  = DEPTH_W'(2);
  localparam logic [VALUE_W-1:0] ADDR_LIMIT = VALUE_W'(MEM_WORDS);

  localparam logic [1:0] SH_HOLD = 2'd0;
  localparam logic [1:0] SH_PUSH = 2'd1;
  localparam logic [1:0] SH_POP1 = 2'd2;
  localparam logic [1:0] SH_POP2 = 2'd3;

  logic [PC_W-1:0]    prog_length;
  logic [PC_W-1:0]    pc;
  logic [PC_W-1:0]    pc_next;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [1:0]         stop;
  logic [1:0]         stop_next;
  logic [1:0]         outcome;

  word_t stk      [STACK_DEPTH];
  word_t stk_next [STACK_DEPTH];
  word_t data_mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_valid;

  word_t              top;
  word_t              below;
  word_t              mem_word;
  word_t              top_new;
  logic               addr_ok;
  logic [AW-1:0]      addr_idx;
  logic [VALUE_W-1:0] sum;
  logic               add_ovf;
  logic [1:0]         shift;
  logic               top_we;
  logic               mem_we;
  logic               mem_clear;
  logic               err;
  logic               halt;

  assign top      = stk[0];
  assign below    = stk[1];
  assign addr_ok  = top.value < ADDR_LIMIT;
  assign addr_idx = top.value[AW-1:0];
  assign mem_word = mem_valid[addr_idx] ? data_mem[addr_idx] : '0;
  assign sum      = top.value + below.value;
  assign add_ovf  = (top.value[VALUE_W-1] == below.value[VALUE_W-1]) &&
                    (sum[VALUE_W-1] != top.value[VALUE_W-1]);

  always_comb begin
    pc_next    = pc;
    depth_next = depth;
    stop_next  = stop;
    outcome    = OC_STEPPED;
    shift      = SH_HOLD;
    top_we     = 1'b0;
    top_new    = top;
    mem_we     = 1'b0;
    mem_clear  = 1'b0;
    err        = 1'b0;
    halt       = 1'b0;
    if (command == CMD_RESTART) begin
      pc_next    = '0;
      depth_next = '0;
      stop_next  = OC_STEPPED;
      mem_clear  = 1'b1;
    end else if (stop != OC_STEPPED) begin
      outcome = stop;
    end else if (pc >= prog_length) begin
      stop_next = OC_EXITED;
      outcome   = OC_EXITED;
    end else begin
      unique case (command)
        CMD_NOOP: begin
        end
        CMD_PUSH: begin
          if (depth >= DEPTH_MAX) begin
            err = 1'b1;
          end else begin
            shift      = SH_PUSH;
            top_we     = 1'b1;
            top_new    = '{tag: imm_tag, value: imm_value};
            depth_next = depth + DEPTH_ONE;
          end
        end
        CMD_POP: begin
          if (depth < DEPTH_ONE) begin
            err = 1'b1;
          end else begin
            shift      = SH_POP1;
            depth_next = depth - DEPTH_ONE;
          end
        end
        CMD_LOAD: begin
          if (depth < DEPTH_ONE || !addr_ok) begin
            err = 1'b1;
          end else begin
            top_we  = 1'b1;
            top_new = '{tag: top.tag | mem_word.tag, value: mem_word.value};
          end
        end
        CMD_STORE: begin
          if (depth < DEPTH_TWO || !addr_ok || (top.tag && !mem_word.tag)) begin
            err = 1'b1;
          end else begin
            mem_we     = 1'b1;
            shift      = SH_POP2;
            depth_next = depth - DEPTH_TWO;
          end
        end
        CMD_ADD: begin
          if (depth < DEPTH_TWO || add_ovf) begin
            err = 1'b1;
          end else begin
            shift      = SH_POP1;
            top_we     = 1'b1;
            top_new    = '{tag: top.tag | below.tag, value: sum};
            depth_next = depth - DEPTH_ONE;
          end
        end
        CMD_HALT: halt = 1'b1;
        default:  err  = 1'b1;
      endcase
      if (err) begin
        stop_next = OC_ERRORED;
        outcome   = OC_ERRORED;
      end else if (halt) begin
        stop_next = OC_HALTED;
        outcome   = OC_HALTED;
      end else begin
        pc_next = pc + 8'd1;
      end
    end
  end

  // stack as a shift line: entry 0 is the top, each entry sees only entries i-1, i+1, i+2
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stk
    word_t prev;
    word_t up1;
    word_t up2;

    if (i > 0) begin : g_prev
      assign prev = stk[i-1];
    end else begin : g_prev_none
      assign prev = stk[i];
    end
    if (i + 1 < STACK_DEPTH) begin : g_up1
      assign up1 = stk[i+1];
    end else begin : g_up1_none
      assign up1 = stk[i];
    end
    if (i + 2 < STACK_DEPTH) begin : g_up2
      assign up2 = stk[i+2];
    end else begin : g_up2_none
      assign up2 = stk[i];
    end

    always_comb begin
      case (shift)
        SH_PUSH: stk_next[i] = prev;
        SH_POP1: stk_next[i] = up1;
        SH_POP2: stk_next[i] = up2;
        default: stk_next[i] = stk[i];
      endcase
      if (i == 0 && top_we) begin
        stk_next[i] = top_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      stk <= stk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_we) begin
      data_mem[addr_idx] <= '{tag: below.tag | top.tag, value: below.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_length <= PROG_LEN_RESET;
      pc          <= '0;
      depth       <= '0;
      stop        <= OC_STEPPED;
      mem_valid   <= '0;
    end else begin
      if (cfg_we) begin
        prog_length <= cfg_data;
      end
      if (fire) begin
        pc    <= pc_next;
        depth <= depth_next;
        stop  <= stop_next;
        if (mem_clear) begin
          mem_valid <= '0;
        end else if (mem_we) begin
          mem_valid[addr_idx] <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.outcome      = outcome;
    result.prog_counter = pc_next;
    result.stack_depth  = depth_next;
    result.top          = (depth_next != '0) ? stk_next[0] : '0;
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_MAX)
    else $error("stack depth beyond capacity");

  a_stopped_frozen: assert property (@(posedge clk) disable iff (rst)
    fire && command != CMD_RESTART && stop != OC_STEPPED
    |=> $stable(pc) && $stable(depth) && $stable(stop))
    else $error("stopped machine changed state");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    fire && command == CMD_RESTART
    |=> pc == '0 && depth == '0 && stop == OC_STEPPED && mem_valid == '0)
    else $error("restart left state behind");

  a_pc_step: assert property (@(posedge clk) disable iff (rst)
    fire |=> pc == $past(pc) || pc == $past(pc) + 8'd1 || pc == '0)
    else $error("instruction count jumped");

endmodule

### design/tsm_out_skid.sv
// ----------------------------------------------------------------------------
// tsm_out_skid - two-entry result buffer
// Output register plus one skid entry; stall upstream only when both are full.
// ----------------------------------------------------------------------------
module tsm_out_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tsm_pkg::res_t data,
  input  logic          res_stall,
  output logic          full,
  output logic          res_valid,
  output tsm_pkg::res_t res
);
  import tsm_pkg::*;

  logic skid_valid;
  res_t skid;
  logic take;

  assign take = res_valid && !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        res <= skid;
      end
    end else if (push) begin
      if (!res_valid || take) begin
        res <= data;
      end else begin
        skid <= data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held with empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    push && res_valid && res_stall |=> skid_valid)
    else $error("item dropped while output stalled");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && take |=> !skid_valid && res_valid)
    else $error("skid entry not moved to output");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the tagged stack machine step block
// Feeds commands through a bursty driver and checks every result item against
// a cycle-free model of the machine kept in the bench. Between phases the
// program_length register is rewritten while the block is idle, and the
// result side stalls on its own pattern with one or more long hold-offs.
// ----------------------------------------------------------------------------
module tb;
  import tsm_pkg::*;

  localparam int STACK_SLOTS    = 10;
  localparam int MEM_SLOTS      = 5;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [VALUE_W-1:0] imm;
    logic               itag;
  } cmd_item_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  // block ports
  logic                      cmd_valid = 1'b0;
  logic                      cmd_stall;
  logic [CMD_W-1:0]          command   = CMD_NOOP;
  logic signed [VALUE_W-1:0] imm_value = '0;
  logic                      imm_tag   = 1'b0;
  logic                      res_valid;
  logic                      res_stall = 1'b0;
  logic [1:0]                outcome;
  logic [PC_W-1:0]           prog_counter;
  logic [DEPTH_W-1:0]        stack_depth;
  logic signed [VALUE_W-1:0] top_value;
  logic                      top_tag;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [PC_W-1:0]           cfg_data  = '0;

  tagged_stack_machine_step #(
    .STACK_DEPTH(STACK_SLOTS),
    .MEM_WORDS  (MEM_SLOTS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .imm_value   (imm_value),
    .imm_tag     (imm_tag),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .outcome     (outcome),
    .prog_counter(prog_counter),
    .stack_depth (stack_depth),
    .top_value   (top_value),
    .top_tag     (top_tag),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // commands waiting to be offered, and results owed by the block
  cmd_item_t pending_q[$];
  res_t      owed_results_q[$];
  logic      item_held = 1'b0;

  // machine model: state and the one register
  logic [PC_W-1:0]    mach_pc    = '0;
  logic [DEPTH_W-1:0] mach_depth = '0;
  logic [1:0]         mach_stop  = OC_STEPPED;
  logic [PC_W-1:0]    mach_len   = PROG_LEN_RESET;
  word_t              mach_stack [STACK_SLOTS];
  word_t              mach_mem   [MEM_SLOTS];

  // bookkeeping
  int queued        = 0;
  int cmds_taken    = 0;
  int results_seen  = 0;
  int fault_count   = 0;
  int len_writes    = 0;
  int outcome_count [4];
  int gap_left      = 0;
  int burst_left    = 1;
  int hold_left     = 0;
  int next_hold_at  = 500;
  int stall_left    = 0;
  int stall_mode    = 0;
  int quiet_cycles  = 0;

  initial begin
    foreach (mach_stack[i]) mach_stack[i] = '0;
    foreach (mach_mem[i]) mach_mem[i] = '0;
    foreach (outcome_count[i]) outcome_count[i] = 0;
  end

  // --------------------------------------------------------------------------
  // Model: run one command on the bench copy of the machine and return the
  // result item it should produce.
  // --------------------------------------------------------------------------
  function automatic res_t exec_command(input logic [CMD_W-1:0] op,
                                        input logic [VALUE_W-1:0] imm,
                                        input logic itag);
    logic [1:0]         oc;
    word_t              top;
    word_t              below;
    logic [VALUE_W-1:0] sum;
    res_t               r;
    if (op == CMD_RESTART) begin
      // clear everything but the stack contents and the register
      mach_pc    = '0;
      mach_depth = '0;
      mach_stop  = OC_STEPPED;
      foreach (mach_mem[i]) mach_mem[i] = '0;
      oc = OC_STEPPED;
    end else if (mach_stop != OC_STEPPED) begin
      oc = mach_stop;
    end else if (mach_pc >= mach_len) begin
      mach_stop = OC_EXITED;
      oc = OC_EXITED;
    end else begin
      oc = OC_STEPPED;
      if (mach_depth >= 1) top = mach_stack[mach_depth - 1];
      else top = '0;
      if (mach_depth >= 2) below = mach_stack[mach_depth - 2];
      else below = '0;
      case (op)
        CMD_NOOP: ;
        CMD_PUSH: begin
          if (mach_depth >= STACK_SLOTS) oc = OC_ERRORED;
          else begin
            mach_stack[mach_depth] = '{tag: itag, value: imm};
            mach_depth = mach_depth + DEPTH_W'(1);
          end
        end
        CMD_POP: begin
          if (mach_depth == 0) oc = OC_ERRORED;
          else mach_depth = mach_depth - DEPTH_W'(1);
        end
        CMD_LOAD: begin
          // negative addresses are huge when seen unsigned
          if (mach_depth == 0 || top.value >= 32'(MEM_SLOTS)) oc = OC_ERRORED;
          else mach_stack[mach_depth - 1] = '{tag: top.tag | mach_mem[top.value].tag,
                                               value: mach_mem[top.value].value};
        end
        CMD_STORE: begin
          if (mach_depth < 2 || top.value >= 32'(MEM_SLOTS)) oc = OC_ERRORED;
          else if (top.tag && !mach_mem[top.value].tag) oc = OC_ERRORED;
          else begin
            mach_mem[top.value] = '{tag: below.tag | top.tag, value: below.value};
            mach_depth = mach_depth - DEPTH_W'(2);
          end
        end
        CMD_ADD: begin
          sum = top.value + below.value;
          if (mach_depth < 2) oc = OC_ERRORED;
          else if (top.value[31] == below.value[31] && sum[31] != top.value[31])
            oc = OC_ERRORED;
          else begin
            mach_stack[mach_depth - 2] = '{tag: below.tag | top.tag, value: sum};
            mach_depth = mach_depth - DEPTH_W'(1);
          end
        end
        CMD_HALT: oc = OC_HALTED;
        default: oc = OC_ERRORED;
      endcase
      if (oc == OC_STEPPED) mach_pc = mach_pc + PC_W'(1);
      else mach_stop = oc;
    end
    r.outcome      = oc;
    r.prog_counter = mach_pc;
    r.stack_depth  = mach_depth;
    if (mach_depth >= 1) r.top = mach_stack[mach_depth - 1];
    else r.top = '0;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] imm,
                          input logic itag);
    cmd_item_t it;
    it.op   = op;
    it.imm  = imm;
    it.itag = itag;
    pending_q.push_back(it);
    queued++;
  endtask

  // operand values: small addresses, sign and overflow edges, full random
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 6);
      3:       return 32'hFFFF_FFFF - $urandom_range(0, 2);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h7FFF_FFFE;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_addr();
    if ($urandom_range(0, 7) != 0) return $urandom_range(0, MEM_SLOTS - 1);
    return rand_word();
  endfunction

  // one program: a restart, then well-formed push/op groups with some noise
  task automatic queue_program();
    int steps;
    add_item(CMD_RESTART, $urandom, 1'($urandom));
    steps = $urandom_range(3, 24);
    repeat (steps) begin
      case ($urandom_range(0, 19))
        0, 1, 2: add_item(CMD_PUSH, rand_word(), 1'($urandom));
        3, 4, 5: begin
          add_item(CMD_PUSH, rand_addr(), $urandom_range(0, 3) == 0);
          add_item(CMD_LOAD, $urandom, 1'($urandom));
        end
        6, 7, 8, 9: begin
          add_item(CMD_PUSH, rand_word(), 1'($urandom));
          add_item(CMD_PUSH, rand_addr(), $urandom_range(0, 3) == 0);
          add_item(CMD_STORE, $urandom, 1'($urandom));
        end
        10, 11, 12: begin
          add_item(CMD_PUSH, rand_word(), 1'($urandom));
          add_item(CMD_PUSH, rand_word(), 1'($urandom));
          add_item(CMD_ADD, $urandom, 1'($urandom));
        end
        13: add_item(CMD_POP, $urandom, 1'($urandom));
        14: add_item(CMD_NOOP, $urandom, 1'($urandom));
        15: add_item(CMD_ADD, $urandom, 1'($urandom));
        16: begin
          if ($urandom_range(0, 2) == 0) add_item(CMD_HALT, $urandom, 1'($urandom));
          else add_item(CMD_LOAD, $urandom, 1'($urandom));
        end
        17: begin
          // fill the stack past its top
          if ($urandom_range(0, 1) == 0) begin
            repeat (STACK_SLOTS + 1) add_item(CMD_PUSH, rand_word(), 1'($urandom));
          end else begin
            add_item(CMD_POP, $urandom, 1'($urandom));
          end
        end
        default: add_item(CMD_W'($urandom_range(0, 7)), $urandom, 1'($urandom));
      endcase
    end
  endtask

  // wait until every queued command has been taken and answered
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || item_held || owed_results_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // write program_length; the model follows at the accepting edge
  task automatic write_prog_len(input logic [PC_W-1:0] len);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    mach_len = len;
    len_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued commands in bursts, record what the model predicts
  // for each accepted one. A stalled item is held unchanged.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && cmd_stall) begin
      // hold
    end else begin
      if (cmd_valid) begin
        owed_results_q.push_back(exec_command(command, imm_value, imm_tag));
        item_held = 1'b0;
        cmds_taken++;
      end
      // keep offering during a long hold-off so the block backs up
      if (gap_left != 0 && hold_left == 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        command   <= nxt.op;
        imm_value <= nxt.imm;
        imm_tag   <= nxt.itag;
        cmd_valid <= 1'b1;
        item_held = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                     (($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) :
                                                    $urandom_range(1, 3));
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest owed one, and
  // drive the result stall from a pattern that changes every stretch.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t want;
    res_t got;
    logic stall_next;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        got.outcome      = outcome;
        got.prog_counter = prog_counter;
        got.stack_depth  = stack_depth;
        got.top.value    = top_value;
        got.top.tag      = top_tag;
        results_seen++;
        if (owed_results_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("result %0d arrived with nothing owed: oc=%0d pc=%0d depth=%0d top=%h/%0d",
                     results_seen, got.outcome, got.prog_counter, got.stack_depth,
                     got.top.value, got.top.tag);
        end else begin
          want = owed_results_q.pop_front();
          outcome_count[want.outcome]++;
          if (got.outcome !== want.outcome || got.prog_counter !== want.prog_counter ||
              got.stack_depth !== want.stack_depth || got.top.value !== want.top.value ||
              got.top.tag !== want.top.tag) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("result %0d mismatch: expected oc=%0d pc=%0d depth=%0d top=%h/%0d",
                       results_seen, want.outcome, want.prog_counter, want.stack_depth,
                       want.top.value, want.top.tag);
              $display("  actual oc=%0d pc=%0d depth=%0d top=%h/%0d",
                       got.outcome, got.prog_counter, got.stack_depth,
                       got.top.value, got.top.tag);
            end
          end
        end
      end
      if (hold_left != 0) begin
        stall_next = 1'b1;
        hold_left <= hold_left - 1;
      end else if (results_seen >= next_hold_at && pending_q.size() > 20) begin
        // long hold-off while the driver keeps pushing
        stall_next = 1'b1;
        hold_left <= LONG_HOLD;
        next_hold_at = next_hold_at + 900;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (stall_mode)
          0:       stall_next = 1'b0;
          1:       stall_next = ($urandom_range(0, 3) == 0);
          2:       stall_next = ($urandom_range(0, 9) < 6);
          default: stall_next = !res_stall;
        endcase
      end
      res_stall <= stall_next;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves on any channel for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases over several
  // program_length settings.
  // --------------------------------------------------------------------------
  initial begin
    int target;
    logic [PC_W-1:0] len;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset length of four: overflowing add, underflow, refused store, halt,
    // stopped machine repeating its code, and the program end
    add_item(CMD_PUSH, 32'h7FFF_FFFF, 1'b0);
    add_item(CMD_PUSH, 32'h0000_0001, 1'b1);
    add_item(CMD_ADD, 32'h0, 1'b0);
    add_item(CMD_NOOP, 32'hFFFF_FFFF, 1'b1);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    add_item(CMD_POP, 32'h0, 1'b0);
    add_item(CMD_RESTART, 32'hFFFF_FFFF, 1'b1);
    add_item(CMD_PUSH, 32'h0000_0002, 1'b0);
    add_item(CMD_PUSH, 32'h0000_0003, 1'b1);
    add_item(CMD_STORE, 32'h0, 1'b0);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    add_item(CMD_HALT, 32'h0, 1'b0);
    add_item(CMD_PUSH, 32'h1234_5678, 1'b1);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    repeat (5) add_item(CMD_NOOP, 32'h0, 1'b0);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    wait_idle();

    // longest program: negative overflow, store then load back, bad addresses
    write_prog_len(8'd255);
    add_item(CMD_PUSH, 32'h8000_0000, 1'b0);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_item(CMD_ADD, 32'h0, 1'b0);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    add_item(CMD_PUSH, 32'h0000_004D, 1'b1);
    add_item(CMD_PUSH, 32'(MEM_SLOTS - 1), 1'b0);
    add_item(CMD_STORE, 32'h0, 1'b0);
    add_item(CMD_PUSH, 32'(MEM_SLOTS - 1), 1'b1);
    add_item(CMD_LOAD, 32'h0, 1'b0);
    add_item(CMD_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_item(CMD_LOAD, 32'h0, 1'b0);
    add_item(CMD_RESTART, 32'h0, 1'b0);
    add_item(CMD_PUSH, 32'(MEM_SLOTS), 1'b0);
    add_item(CMD_LOAD, 32'h0, 1'b0);
    wait_idle();

    // random phases; lengths of zero and one stop almost at once, keep short
    target = queued;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       len = 8'd255;
        1:       len = 8'd1;
        2:       len = 8'd0;
        3:       len = 8'd12;
        4:       len = 8'd255;
        5:       len = PC_W'($urandom_range(2, 40));
        6:       len = 8'd6;
        7:       len = 8'd254;
        8:       len = PC_W'($urandom_range(1, 255));
        default: len = 8'd30;
      endcase
      write_prog_len(len);
      target = target + ((len <= 1) ? 40 : 230);
      while (queued < target) queue_program();
      wait_idle();
    end

    // let any stray result show up before the verdict
    repeat (10) @(posedge clk);
    $display("Ran %0d commands under %0d program_length settings, %0d results checked",
             cmds_taken, len_writes + 1, results_seen);
    $display("Outcomes: %0d stepped, %0d errored, %0d halted, %0d exited",
             outcome_count[OC_STEPPED], outcome_count[OC_ERRORED],
             outcome_count[OC_HALTED], outcome_count[OC_EXITED]);
    if (fault_count == 0 && owed_results_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d faults, %0d results still owed", fault_count, owed_results_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
